// File: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: hdl/lzwe_pkg.sv
package lzwe_pkg;

   localparam int TABLE_SLOTS   = 5003;
   localparam int MAX_CODE_BITS = 12;

   localparam int CODE_BITS = 12;
   localparam int SLOT_AW   = $clog2(TABLE_SLOTS);

   localparam logic [SLOT_AW-1:0]   LAST_SLOT  = SLOT_AW'(TABLE_SLOTS - 1);
   localparam logic [CODE_BITS-1:0] FULL_CODE  = CODE_BITS'((1 << MAX_CODE_BITS) - 1);
   localparam logic [CODE_BITS-1:0] CLEAR_CODE = CODE_BITS'(256);
   localparam logic [CODE_BITS-1:0] END_CODE   = CODE_BITS'(257);
   localparam logic [CODE_BITS-1:0] FIRST_FREE = CODE_BITS'(258);
   localparam logic [3:0]           START_WIDTH = 4'd9;
   localparam logic [31:0]          EMPTY_SLOT = 32'hffff_ffff;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      logic [31:0] packed_word;
      logic        last_word;
   } rsp_item_type;

   typedef enum logic [3:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_LOOK,
      ST_MISS,
      ST_MISS_CLR,
      ST_FIN_PREFIX,
      ST_FIN_CLR,
      ST_FIN_END,
      ST_FIN_FLUSH
   } state_type;

endpackage

// File: hdl/lzw_encoder_top.sv
// LZW byte compressor, 9 to 12 bit codes packed LSB-first into 32-bit words
// (clear = 256, end = 257). A byte with last_byte set closes the stream; its
// final word carries last_word. Bytes land in a two-entry queue and words
// leave through a four-entry queue. A byte whose (prefix, byte) pair is in
// the dictionary takes a hash-table read, then a compare, plus a read per
// probe collision; a miss adds a step to emit the code and write the new
// entry, and end of stream adds flush steps (prefix, clear if the table is
// full, end code, last partial word). Output backpressure stalls the emit
// steps. The single-port dictionary RAM is swept empty after reset, after each
// clear code and after each stream; no byte leaves the input queue in a sweep.
`include "assert_macros.svh"

module lzw_encoder_top
   import lzwe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   input  logic        rsp_pop,
   output logic        rsp_empty,
   output logic [31:0] rsp_packed_word,
   output logic        rsp_last_word
);

   req_item_type req_in_item, req_head;
   rsp_item_type rsp_item, rsp_head;
   logic         q_req_empty, q_req_pop;
   logic         q_rsp_full, q_rsp_push;

   assign req_in_item = '{data_byte: req_data_byte, last_byte: req_last_byte};

   lzwe_req_queue u_req_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_item (req_in_item),
      .full      (req_full),
      .pop       (q_req_pop),
      .empty     (q_req_empty),
      .head      (req_head)
   );

   lzwe_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_empty (q_req_empty),
      .req_head  (req_head),
      .req_pop   (q_req_pop),
      .rsp_full  (q_rsp_full),
      .rsp_push  (q_rsp_push),
      .rsp_item  (rsp_item)
   );

   lzwe_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_rsp_push),
      .push_item (rsp_item),
      .full      (q_rsp_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (rsp_head)
   );

   assign rsp_packed_word = rsp_head.packed_word;
   assign rsp_last_word   = rsp_head.last_word;

   `ASSERT_NOW(a_rsp_no_overflow, q_rsp_push, !q_rsp_full)
   `ASSERT_NOW(a_req_no_underflow, q_req_pop, !q_req_empty)
   `ASSERT_NEXT(a_rsp_word_shows, q_rsp_push && rsp_empty, !rsp_empty)

endmodule

// File: hdl/lzwe_ram.sv
module lzwe_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     we,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

// File: hdl/lzwe_req_queue.sv
module lzwe_req_queue
   import lzwe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  req_item_type push_item,
   output logic         full,
   input  logic         pop,
   output logic         empty,
   output req_item_type head
);

   req_item_type mem_ff [2];
   logic         wr_ff, wr_in;
   logic         rd_ff, rd_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         do_push, do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign head    = mem_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in  = do_push ? !wr_ff : wr_ff;
      rd_in  = do_pop ? !rd_ff : rd_ff;
      cnt_in = cnt_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

// File: hdl/lzwe_rsp_queue.sv
module lzwe_rsp_queue
   import lzwe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  rsp_item_type push_item,
   output logic         full,
   input  logic         pop,
   output logic         empty,
   output rsp_item_type head
);

   rsp_item_type mem_ff [4];
   logic [1:0]   wr_ff, wr_in;
   logic [1:0]   rd_ff, rd_in;
   logic [2:0]   cnt_ff, cnt_in;
   logic         do_push, do_pop;

   assign full    = (cnt_ff == 3'd4);
   assign empty   = (cnt_ff == 3'd0);
   assign head    = mem_ff[rd_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_in  = do_push ? wr_ff + 2'd1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 2'd1 : rd_ff;
      cnt_in = cnt_ff + {2'b0, do_push} - {2'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 2'd0;
         rd_ff  <= 2'd0;
         cnt_ff <= 3'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

endmodule

// File: hdl/lzwe_engine.sv
module lzwe_engine
   import lzwe_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_empty,
   input  req_item_type req_head,
   output logic         req_pop,
   input  logic         rsp_full,
   output logic         rsp_push,
   output rsp_item_type rsp_item
);

   state_type            state_ff, state_in;
   logic [CODE_BITS-1:0] prefix_ff, prefix_in;
   logic                 have_ff, have_in;
   logic [CODE_BITS-1:0] nf_ff, nf_in;
   logic [3:0]           width_ff, width_in;
   logic [4:0]           fill_ff, fill_in;
   logic [31:0]          partial_ff, partial_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 last_ff, last_in;
   logic [SLOT_AW-1:0]   idx_ff, idx_in;
   logic [SLOT_AW-1:0]   sweep_ff, sweep_in;

   logic [SLOT_AW-1:0]   ram_addr;
   logic                 ram_we;
   logic [31:0]          ram_wdata;
   logic [31:0]          ram_rdata;

   logic [CODE_BITS-1:0] emit_code;
   logic [CODE_BITS-1:0] code_masked;
   logic [43:0]          shifted;
   logic [5:0]           fill_sum;
   logic                 word_done;
   logic [31:0]          word;
   logic                 emit_go;
   logic                 restart_all;
   logic                 grow;
   logic [SLOT_AW-1:0]   hash_idx;
   logic [SLOT_AW-1:0]   next_idx;

   lzwe_ram #(.WIDTH(32), .DEPTH(TABLE_SLOTS)) u_dict (
      .clock (clock),
      .addr  (ram_addr),
      .we    (ram_we),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_comb begin
      case (state_ff)
         ST_MISS_CLR, ST_FIN_CLR: emit_code = CLEAR_CODE;
         ST_FIN_END:              emit_code = END_CODE;
         default:                 emit_code = prefix_ff;
      endcase
   end

   assign code_masked = emit_code & ~({CODE_BITS{1'b1}} << width_ff);
   assign shifted     = 44'(code_masked) << fill_ff;
   assign fill_sum    = {1'b0, fill_ff} + {2'b0, width_ff};
   assign word_done   = fill_sum[5];
   assign word        = partial_ff | shifted[31:0];
   assign grow        = {1'b0, nf_ff} >= ((CODE_BITS + 1)'(1) << width_ff);
   assign hash_idx    = SLOT_AW'({req_head.data_byte, 4'b0} | prefix_ff);
   assign next_idx    = (idx_ff == LAST_SLOT) ? '0 : idx_ff + SLOT_AW'(1);

   always_comb begin
      state_in    = state_ff;
      prefix_in   = prefix_ff;
      have_in     = have_ff;
      nf_in       = nf_ff;
      width_in    = width_ff;
      fill_in     = fill_ff;
      partial_in  = partial_ff;
      byte_in     = byte_ff;
      last_in     = last_ff;
      idx_in      = idx_ff;
      sweep_in    = sweep_ff;
      ram_addr    = idx_ff;
      ram_we      = 1'b0;
      ram_wdata   = EMPTY_SLOT;
      req_pop     = 1'b0;
      rsp_push    = 1'b0;
      rsp_item    = '{packed_word: word, last_word: 1'b0};
      emit_go     = 1'b0;
      restart_all = 1'b0;

      case (state_ff)
         ST_SWEEP: begin
            ram_we   = 1'b1;
            ram_addr = sweep_ff;
            if (sweep_ff == LAST_SLOT) begin
               sweep_in = '0;
               state_in = last_ff ? ST_FIN_PREFIX : ST_IDLE;
            end else begin
               sweep_in = sweep_ff + SLOT_AW'(1);
            end
         end
         ST_IDLE: begin
            if (!req_empty) begin
               req_pop = 1'b1;
               byte_in = req_head.data_byte;
               last_in = req_head.last_byte;
               if (!have_ff) begin
                  prefix_in = CODE_BITS'(req_head.data_byte);
                  have_in   = 1'b1;
                  state_in  = req_head.last_byte ? ST_FIN_PREFIX : ST_IDLE;
               end else begin
                  idx_in   = hash_idx;
                  ram_addr = hash_idx;
                  state_in = ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            if (ram_rdata == EMPTY_SLOT) begin
               state_in = ST_MISS;
            end else if (ram_rdata[19:0] == {prefix_ff, byte_ff}) begin
               prefix_in = ram_rdata[31:20];
               state_in  = last_ff ? ST_FIN_PREFIX : ST_IDLE;
            end else begin
               idx_in   = next_idx;
               ram_addr = next_idx;
            end
         end
         ST_MISS: begin
            if (!rsp_full) begin
               emit_go   = 1'b1;
               prefix_in = CODE_BITS'(byte_ff);
               if (nf_ff >= FULL_CODE) begin
                  state_in = ST_MISS_CLR;
               end else begin
                  if (grow) begin
                     width_in = width_ff + 4'd1;
                  end
                  ram_we    = 1'b1;
                  ram_wdata = {nf_ff, prefix_ff, byte_ff};
                  nf_in     = nf_ff + CODE_BITS'(1);
                  state_in  = last_ff ? ST_FIN_PREFIX : ST_IDLE;
               end
            end
         end
         ST_MISS_CLR: begin
            if (!rsp_full) begin
               emit_go  = 1'b1;
               width_in = START_WIDTH;
               nf_in    = FIRST_FREE;
               sweep_in = '0;
               state_in = ST_SWEEP;
            end
         end
         ST_FIN_PREFIX: begin
            if (!rsp_full) begin
               emit_go = 1'b1;
               if (nf_ff >= FULL_CODE) begin
                  state_in = ST_FIN_CLR;
               end else begin
                  if (grow) begin
                     width_in = width_ff + 4'd1;
                  end
                  state_in = ST_FIN_END;
               end
            end
         end
         ST_FIN_CLR: begin
            if (!rsp_full) begin
               emit_go  = 1'b1;
               width_in = START_WIDTH;
               nf_in    = FIRST_FREE;
               state_in = ST_FIN_END;
            end
         end
         ST_FIN_END: begin
            if (!rsp_full) begin
               emit_go = 1'b1;
               rsp_item.last_word = (fill_sum[4:0] == 5'd0);
               if (fill_sum[4:0] == 5'd0) begin
                  restart_all = 1'b1;
               end else begin
                  state_in = ST_FIN_FLUSH;
               end
            end
         end
         ST_FIN_FLUSH: begin
            if (!rsp_full) begin
               rsp_push    = 1'b1;
               rsp_item    = '{packed_word: partial_ff, last_word: 1'b1};
               restart_all = 1'b1;
            end
         end
         default: begin
            state_in = ST_SWEEP;
         end
      endcase

      if (emit_go) begin
         rsp_push   = word_done;
         fill_in    = fill_sum[4:0];
         partial_in = word_done ? 32'(shifted[43:32]) : word;
      end

      if (restart_all) begin
         prefix_in  = '0;
         have_in    = 1'b0;
         nf_in      = FIRST_FREE;
         width_in   = START_WIDTH;
         fill_in    = '0;
         partial_in = '0;
         last_in    = 1'b0;
         sweep_in   = '0;
         state_in   = ST_SWEEP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_SWEEP;
         prefix_ff  <= '0;
         have_ff    <= 1'b0;
         nf_ff      <= FIRST_FREE;
         width_ff   <= START_WIDTH;
         fill_ff    <= '0;
         partial_ff <= '0;
         last_ff    <= 1'b0;
         sweep_ff   <= '0;
      end else begin
         state_ff   <= state_in;
         prefix_ff  <= prefix_in;
         have_ff    <= have_in;
         nf_ff      <= nf_in;
         width_ff   <= width_in;
         fill_ff    <= fill_in;
         partial_ff <= partial_in;
         last_ff    <= last_in;
         sweep_ff   <= sweep_in;
      end
      byte_ff <= byte_in;
      idx_ff  <= idx_in;
   end

endmodule
